// File: src/ecgf212_pkg.sv
// Shared constants and helpers for the format 212 / 16-bit sample unpacker.
// No dependencies.
`default_nettype none

package ecgf212_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEAD_W     = 2;
    localparam int COUNT_W    = 3;
    localparam int BASE_W     = 16;
    localparam int SAMPLE_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 2;

    // Number of lead slots carried by the record
    localparam int MAX_LEADS  = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE3     = 3'd5;

    // Format codes
    localparam logic FMT_212   = 1'b0;
    localparam logic FMT_16BIT = 1'b1;

    // Byte position within a group
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MIDDLE = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [LEAD_W-1:0]          lead;
    } result_t;

    // Lead count with zero taken as one and values above the slot count clamped
    function automatic logic [COUNT_W-1:0] effective_leads(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        begin
            r = n;
            if (n == '0)
            begin
                r = COUNT_W'(1);
            end
            else if (n > COUNT_W'(MAX_LEADS))
            begin
                r = COUNT_W'(MAX_LEADS);
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/ecg_format212_sample_unpacker.sv
// Each result is registered in a two-entry output (register plus skid): in the
// output register, or in the skid entry while the output is held. Input takes
// one byte per cycle while the skid is empty, even with one result waiting.
// Reset (rst_n low, async): phase, held bytes, lead and output valids cleared;
// format 212, lead_count 1, baselines 0. Uses ecgf212_pkg.
`default_nettype none

module ecg_format212_sample_unpacker
    import ecgf212_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,

    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [BYTE_W-1:0]            record_byte,

    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic signed [SAMPLE_W-1:0]   sample_value,
    output      logic [LEAD_W-1:0]            lead_index
);

    logic                       format_select_reg;
    logic [COUNT_W-1:0]         lead_count_reg;
    logic [BASE_W-1:0]          baseline_reg [MAX_LEADS];

    logic [PHASE_W-1:0]         byte_phase_reg, byte_phase_next;
    logic [BYTE_W-1:0]          held_first_reg, held_first_next;
    logic [BYTE_W-1:0]          held_middle_reg, held_middle_next;
    logic [LEAD_W-1:0]          current_lead_reg, current_lead_next;

    result_t                    out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    skid_reg, skid_next;
    logic                       skid_valid_reg, skid_valid_next;

    logic                       in_fire, out_fire;
    logic                       emit;
    logic                       packed_mode;
    logic [BASE_W-1:0]          raw16;
    logic [BASE_W-1:0]          base;
    logic [BASE_W-1:0]          diff16;
    logic [SAMPLE_W-1:0]        diff17;
    logic [COUNT_W-1:0]         eff_leads;
    logic [COUNT_W-1:0]         lead_plus1;
    result_t                    result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid    = out_valid_reg;
    assign sample_value = out_reg.value;
    assign lead_index   = out_reg.lead;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_select_reg <= FMT_212;
            lead_count_reg    <= COUNT_W'(1);
            for (int i = 0; i < MAX_LEADS; i++)
            begin
                baseline_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FORMAT_SELECT: format_select_reg <= cfg_data[0];
                REG_LEAD_COUNT:    lead_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_BASELINE0:     baseline_reg[0]   <= cfg_data[BASE_W-1:0];
                REG_BASELINE1:     baseline_reg[1]   <= cfg_data[BASE_W-1:0];
                REG_BASELINE2:     baseline_reg[2]   <= cfg_data[BASE_W-1:0];
                REG_BASELINE3:     baseline_reg[3]   <= cfg_data[BASE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Byte sequencing and sample assembly
    always_comb
    begin
        byte_phase_next  = byte_phase_reg;
        held_first_next  = held_first_reg;
        held_middle_next = held_middle_reg;
        emit             = 1'b0;
        packed_mode      = (format_select_reg == FMT_212);
        raw16            = '0;

        if (byte_phase_reg == PH_FIRST)
        begin
            held_first_next = record_byte;
            byte_phase_next = PH_MIDDLE;
        end
        else if (!packed_mode)
        begin
            // any nonzero phase is the high byte of a pair
            emit            = 1'b1;
            byte_phase_next = PH_FIRST;
            raw16           = {record_byte, held_first_reg};
        end
        else if (byte_phase_reg == PH_MIDDLE)
        begin
            emit             = 1'b1;
            held_middle_next = record_byte;
            byte_phase_next  = PHASE_W'(2);
            raw16            = {{4{record_byte[3]}}, record_byte[3:0], held_first_reg};
        end
        else
        begin
            emit            = 1'b1;
            byte_phase_next = PH_FIRST;
            raw16           = {{4{held_middle_reg[7]}}, held_middle_reg[7:4], record_byte};
        end
    end

    // Baseline removal and lead rotation
    always_comb
    begin
        base   = baseline_reg[current_lead_reg];
        diff16 = raw16 - base;
        diff17 = {raw16[BASE_W-1], raw16} - {base[BASE_W-1], base};

        result.lead  = current_lead_reg;
        result.value = packed_mode ? $signed({diff16[BASE_W-1], diff16}) : $signed(diff17);

        eff_leads         = effective_leads(lead_count_reg);
        lead_plus1        = {1'b0, current_lead_reg} + COUNT_W'(1);
        current_lead_next = current_lead_reg;
        if (emit)
        begin
            current_lead_next = (lead_plus1 >= eff_leads) ? '0 : lead_plus1[LEAD_W-1:0];
        end
    end

    // Output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_next       = result;
            out_valid_next = in_fire && emit;
        end
        else if (in_fire && emit)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg   <= PH_FIRST;
            held_first_reg   <= '0;
            held_middle_reg  <= '0;
            current_lead_reg <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_phase_reg   <= byte_phase_next;
                held_first_reg   <= held_first_next;
                held_middle_reg  <= held_middle_next;
                current_lead_reg <= current_lead_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
